### rtl/core/rsi_pkg.sv
// Package for the ray/segment intersection unit: widths and item types.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package rsi_pkg;

  localparam int CoordW = 32;               // coordinate width, signed Q16.16
  localparam int DiffW  = CoordW + 1;       // coordinate difference
  localparam int ProdW  = 2 * DiffW;        // one cross-product term
  localparam int DenW   = ProdW + 1;        // den, t_num, u_num
  localparam int LoW    = DenW / 2;         // low half of |t_num| for the split multiply
  localparam int HiW    = DenW - LoW;
  localparam int MulW   = DenW + DiffW;     // |t_num| * |B-A|
  localparam int QuoW   = DiffW;            // quotient bits, |q| < |B-A|
  localparam int SumW   = DiffW + 2;        // A + q before saturation

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] seg_a_x;
    logic signed [CoordW-1:0] seg_a_y;
    logic signed [CoordW-1:0] seg_b_x;
    logic signed [CoordW-1:0] seg_b_y;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic                     parallel;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/rsi_in_if.sv
// Input channel of the intersection unit: valid, ready and one test item.
// Depends on rsi_pkg.
`default_nettype none
interface rsi_in_if;
  import rsi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/rsi_out_if.sv
// Result channel of the intersection unit: valid, ready and one result item.
// Depends on rsi_pkg.
`default_nettype none
interface rsi_out_if;
  import rsi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/ray_segment_intersection_unit.sv
// Pipelined 2D ray against segment intersection test, Q16.16 fixed point.
// Depends on rsi_pkg, rsi_in_if and rsi_out_if.
//
//   channel | dir | carries
//   in_i    | in  | origin, direction, segment endpoints A and B
//   out_o   | out | hit, parallel, hit_x, hit_y
//
// One item enters per cycle unless the output stalls. The restoring divider
// resolves one quotient bit per stage for both axes. Reset clears only the
// valid bits. When the output register holds a result that is not taken,
// every stage holds and in_i.ready drops; nothing is lost or repeated.
`default_nettype none
module ray_segment_intersection_unit (
  input  wire    clk_i,
  input  wire    rst_ni,
  rsi_in_if.sink    in_i,
  rsi_out_if.source out_o
);
  import rsi_pkg::*;

  logic en;
  logic out_valid_q;
  out_item_t out_q, out_d;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // stage 1: differences
  logic v1_q;
  logic signed [DiffW-1:0] e12x_q, e12y_q, e13x_q, e13y_q, ebx_q, eby_q, dx_q, dy_q;
  logic signed [CoordW-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e12x_q <= DiffW'(in_i.data.seg_a_x) - DiffW'(in_i.data.seg_b_x);
      e12y_q <= DiffW'(in_i.data.seg_a_y) - DiffW'(in_i.data.seg_b_y);
      e13x_q <= DiffW'(in_i.data.seg_a_x) - DiffW'(in_i.data.origin_x);
      e13y_q <= DiffW'(in_i.data.seg_a_y) - DiffW'(in_i.data.origin_y);
      ebx_q  <= DiffW'(in_i.data.seg_b_x) - DiffW'(in_i.data.seg_a_x);
      eby_q  <= DiffW'(in_i.data.seg_b_y) - DiffW'(in_i.data.seg_a_y);
      dx_q   <= DiffW'(in_i.data.dir_x);
      dy_q   <= DiffW'(in_i.data.dir_y);
      ax1_q  <= in_i.data.seg_a_x;
      ay1_q  <= in_i.data.seg_a_y;
    end
  end

  // stage 2: cross-product terms
  logic v2_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DiffW-1:0] ebx2_q, eby2_q;
  logic signed [CoordW-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q   <= ProdW'(e12y_q) * ProdW'(dx_q);
      p1_q   <= ProdW'(e12x_q) * ProdW'(dy_q);
      p2_q   <= ProdW'(e13y_q) * ProdW'(dx_q);
      p3_q   <= ProdW'(e13x_q) * ProdW'(dy_q);
      p4_q   <= ProdW'(e12y_q) * ProdW'(e13x_q);
      p5_q   <= ProdW'(e12x_q) * ProdW'(e13y_q);
      ebx2_q <= ebx_q;
      eby2_q <= eby_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  // stage 3: den, t_num, u_num
  logic v3_q;
  logic signed [DenW-1:0] den_q, tn_q, un_q;
  logic signed [DiffW-1:0] ebx3_q, eby3_q;
  logic signed [CoordW-1:0] ax3_q, ay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q  <= DenW'(p0_q) - DenW'(p1_q);
      tn_q   <= DenW'(p2_q) - DenW'(p3_q);
      un_q   <= DenW'(p4_q) - DenW'(p5_q);
      ebx3_q <= ebx2_q;
      eby3_q <= eby2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  // stage 4: hit decision from signs and magnitudes, magnitudes for the divide
  logic v4_q, hit4_q, par4_q, negx4_q, negy4_q;
  logic [DenW-1:0]  ud4_q, ut4_q;
  logic [DiffW-1:0] mx4_q, my4_q;
  logic signed [CoordW-1:0] ax4_q, ay4_q;
  logic dneg, tneg, uneg, hit_d;
  logic [DenW-1:0] ud_d, ut_d;

  always_comb begin
    dneg  = den_q[DenW-1];
    tneg  = tn_q[DenW-1];
    uneg  = un_q[DenW-1];
    ud_d  = dneg ? DenW'(-den_q) : DenW'(den_q);
    ut_d  = tneg ? DenW'(-tn_q) : DenW'(tn_q);
    hit_d = (den_q != '0) && (tn_q != '0) && (tneg == dneg) && (ut_d < ud_d) &&
            (un_q != '0) && (uneg == dneg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit4_q  <= hit_d;
      par4_q  <= (den_q == '0);
      ud4_q   <= ud_d;
      ut4_q   <= ut_d;
      mx4_q   <= ebx3_q[DiffW-1] ? DiffW'(-ebx3_q) : DiffW'(ebx3_q);
      my4_q   <= eby3_q[DiffW-1] ? DiffW'(-eby3_q) : DiffW'(eby3_q);
      negx4_q <= tneg ^ dneg ^ ebx3_q[DiffW-1];
      negy4_q <= tneg ^ dneg ^ eby3_q[DiffW-1];
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
    end
  end

  // stage 5: partial products of |t_num| * |B-A|
  logic v5_q, hit5_q, par5_q, negx5_q, negy5_q;
  logic [DenW-1:0] ud5_q;
  logic [LoW+DiffW-1:0] plx_q, ply_q;
  logic [HiW+DiffW-1:0] phx_q, phy_q;
  logic signed [CoordW-1:0] ax5_q, ay5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plx_q   <= (LoW+DiffW)'(ut4_q[LoW-1:0]) * (LoW+DiffW)'(mx4_q);
      ply_q   <= (LoW+DiffW)'(ut4_q[LoW-1:0]) * (LoW+DiffW)'(my4_q);
      phx_q   <= (HiW+DiffW)'(ut4_q[DenW-1:LoW]) * (HiW+DiffW)'(mx4_q);
      phy_q   <= (HiW+DiffW)'(ut4_q[DenW-1:LoW]) * (HiW+DiffW)'(my4_q);
      hit5_q  <= hit4_q;
      par5_q  <= par4_q;
      ud5_q   <= ud4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  // stage 6: combine partial products
  logic v6_q, hit6_q, par6_q, negx6_q, negy6_q;
  logic [DenW-1:0] ud6_q;
  logic [MulW-1:0] prx6_q, pry6_q;
  logic signed [CoordW-1:0] ax6_q, ay6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx6_q  <= MulW'(plx_q) + (MulW'(phx_q) << LoW);
      pry6_q  <= MulW'(ply_q) + (MulW'(phy_q) << LoW);
      hit6_q  <= hit5_q;
      par6_q  <= par5_q;
      ud6_q   <= ud5_q;
      negx6_q <= negx5_q;
      negy6_q <= negy5_q;
      ax6_q   <= ax5_q;
      ay6_q   <= ay5_q;
    end
  end

  // divider: one quotient bit per stage for both axes. On a hit the product
  // is below |den| << QuoW, so the top part starts below |den|.
  logic            dv_q   [QuoW];
  logic            dhit_q [QuoW];
  logic            dpar_q [QuoW];
  logic            dnx_q  [QuoW];
  logic            dny_q  [QuoW];
  logic [DenW-1:0] dud_q  [QuoW];
  logic [DenW-1:0] drx_q  [QuoW];
  logic [DenW-1:0] dry_q  [QuoW];
  logic [QuoW-1:0] dlx_q  [QuoW];
  logic [QuoW-1:0] dly_q  [QuoW];
  logic [QuoW-1:0] dqx_q  [QuoW];
  logic [QuoW-1:0] dqy_q  [QuoW];
  logic signed [CoordW-1:0] dax_q [QuoW];
  logic signed [CoordW-1:0] day_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic            v_in, hit_in, par_in, nx_in, ny_in;
    logic [DenW-1:0] ud_in, rx_in, ry_in;
    logic [QuoW-1:0] lx_in, ly_in, qx_in, qy_in;
    logic signed [CoordW-1:0] ax_in, ay_in;
    logic [DenW:0]   tx, ty;
    logic            bx, by;

    if (k == 0) begin : g_first
      assign v_in   = v6_q;
      assign hit_in = hit6_q;
      assign par_in = par6_q;
      assign nx_in  = negx6_q;
      assign ny_in  = negy6_q;
      assign ud_in  = ud6_q;
      assign rx_in  = prx6_q[MulW-1:QuoW];
      assign ry_in  = pry6_q[MulW-1:QuoW];
      assign lx_in  = prx6_q[QuoW-1:0];
      assign ly_in  = pry6_q[QuoW-1:0];
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign ax_in  = ax6_q;
      assign ay_in  = ay6_q;
    end else begin : g_next
      assign v_in   = dv_q[k-1];
      assign hit_in = dhit_q[k-1];
      assign par_in = dpar_q[k-1];
      assign nx_in  = dnx_q[k-1];
      assign ny_in  = dny_q[k-1];
      assign ud_in  = dud_q[k-1];
      assign rx_in  = drx_q[k-1];
      assign ry_in  = dry_q[k-1];
      assign lx_in  = dlx_q[k-1];
      assign ly_in  = dly_q[k-1];
      assign qx_in  = dqx_q[k-1];
      assign qy_in  = dqy_q[k-1];
      assign ax_in  = dax_q[k-1];
      assign ay_in  = day_q[k-1];
    end

    assign tx = {rx_in, lx_in[QuoW-1]};
    assign ty = {ry_in, ly_in[QuoW-1]};
    assign bx = (tx >= {1'b0, ud_in});
    assign by = (ty >= {1'b0, ud_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else if (en) dv_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drx_q[k]  <= bx ? DenW'(tx - {1'b0, ud_in}) : DenW'(tx);
        dry_q[k]  <= by ? DenW'(ty - {1'b0, ud_in}) : DenW'(ty);
        dlx_q[k]  <= lx_in << 1;
        dly_q[k]  <= ly_in << 1;
        dqx_q[k]  <= {qx_in[QuoW-2:0], bx};
        dqy_q[k]  <= {qy_in[QuoW-2:0], by};
        dhit_q[k] <= hit_in;
        dpar_q[k] <= par_in;
        dnx_q[k]  <= nx_in;
        dny_q[k]  <= ny_in;
        dud_q[k]  <= ud_in;
        dax_q[k]  <= ax_in;
        day_q[k]  <= ay_in;
      end
    end
  end

  // output: apply sign, add A, saturate; zero the point on a miss
  logic signed [SumW-1:0] qsx, qsy, sx, sy;
  logic signed [CoordW-1:0] satx, saty;

  always_comb begin
    qsx = dnx_q[QuoW-1] ? -SumW'(dqx_q[QuoW-1]) : SumW'(dqx_q[QuoW-1]);
    qsy = dny_q[QuoW-1] ? -SumW'(dqy_q[QuoW-1]) : SumW'(dqy_q[QuoW-1]);
    sx  = SumW'(dax_q[QuoW-1]) + qsx;
    sy  = SumW'(day_q[QuoW-1]) + qsy;
    if (sx[SumW-1:CoordW-1] == '0 || sx[SumW-1:CoordW-1] == '1) satx = sx[CoordW-1:0];
    else satx = sx[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    if (sy[SumW-1:CoordW-1] == '0 || sy[SumW-1:CoordW-1] == '1) saty = sy[CoordW-1:0];
    else saty = sy[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    out_d.hit      = dhit_q[QuoW-1];
    out_d.parallel = dpar_q[QuoW-1];
    out_d.hit_x    = dhit_q[QuoW-1] ? satx : '0;
    out_d.hit_y    = dhit_q[QuoW-1] ? saty : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dv_q[QuoW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.hit |-> out_q.hit_x == '0 && out_q.hit_y == '0)
    else $error("miss result carries a nonzero point");
  a_par_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.parallel))
    else $error("result both hit and parallel");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted item not in first stage");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q) && $stable(v1_q))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire
